@@ design/tll_pkg.sv @@
// shared types and constants for the toy language lexer
package tll_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_line;
    } src_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [2:0]  keyword_id;
        logic [7:0]  symbol_char;
        logic [63:0] name_chars;
        logic [3:0]  name_length;
        logic        name_truncated;
        logic [31:0] number_value;
        logic        number_saturated;
        logic        last;
    } tok_t;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_NAME   = 2'd1,
        MODE_NUMBER = 2'd2
    } mode_t;

    localparam logic [2:0] KIND_KEYWORD  = 3'd0;
    localparam logic [2:0] KIND_IDENT    = 3'd1;
    localparam logic [2:0] KIND_CONSTANT = 3'd2;
    localparam logic [2:0] KIND_OPERATOR = 3'd3;
    localparam logic [2:0] KIND_SYMBOL   = 3'd4;

    localparam logic [2:0] KW_INT   = 3'd0;
    localparam logic [2:0] KW_IF    = 3'd1;
    localparam logic [2:0] KW_THEN  = 3'd2;
    localparam logic [2:0] KW_ELSE  = 3'd3;
    localparam logic [2:0] KW_ENDIF = 3'd4;

    // keyword text, first character in the low byte
    localparam logic [63:0] KW_INT_TEXT   = 64'h0000_0000_0074_6e69;
    localparam logic [63:0] KW_IF_TEXT    = 64'h0000_0000_0000_6669;
    localparam logic [63:0] KW_THEN_TEXT  = 64'h0000_0000_6e65_6874;
    localparam logic [63:0] KW_ELSE_TEXT  = 64'h0000_0000_6573_6c65;
    localparam logic [63:0] KW_ENDIF_TEXT = 64'h0000_0066_6964_6e65;
    localparam logic [3:0]  KW_INT_LEN    = 4'd3;
    localparam logic [3:0]  KW_IF_LEN     = 4'd2;
    localparam logic [3:0]  KW_THEN_LEN   = 4'd4;
    localparam logic [3:0]  KW_ELSE_LEN   = 4'd4;
    localparam logic [3:0]  KW_ENDIF_LEN  = 4'd5;

    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7a;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5a;

endpackage

@@ design/toy_language_lexer.sv @@
// toy language lexer: characters in, tokens out
//
// src channel takes one character per beat (or an end-of-line beat); tok channel
// gives one token per beat, with last set on the final token a beat caused.
// A beat causes zero, one or two tokens.
// An accepted beat is held in the input register until the queue has room for two
// tokens; then it is classified against the comment and token state and its tokens
// are written into a four-entry output queue, which drives tok_valid.
// A new beat is taken every cycle as long as the queue has room for two tokens;
// a beat that yields at most one token keeps that pace, one yielding two tokens
// fills the queue faster than it drains, so the tok side then sets the rate.
// Names and numbers are closed only by the character after them or by end of line.
// When tok_stall is held the queue fills and src_stall rises; nothing is dropped.
// Reset empties the input register and queue and clears all lexer state
// (no open token, no comment, no pending slash).
module toy_language_lexer
    import tll_pkg::*;
#(
    parameter int MAX_NAME_CHARS = 8,
    parameter int NUMBER_BITS    = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic src_valid,
    output logic src_stall,
    input  src_t src_data,
    output logic tok_valid,
    input  logic tok_stall,
    output tok_t tok_data
);

    localparam logic [3:0] KEEP_CHARS = 4'(MAX_NAME_CHARS);
    localparam int         EXT_BITS   = NUMBER_BITS + 4;

    // input register
    logic src_valid_reg, src_valid_next;
    src_t src_reg;

    // lexer state
    logic                   in_block_reg, in_block_next;
    logic                   in_line_reg, in_line_next;
    logic                   pend_slash_reg, pend_slash_next;
    logic                   pend_star_reg, pend_star_next;
    mode_t                  mode_reg, mode_next;
    logic [63:0]            name_buf_reg, name_buf_next;
    logic [3:0]             name_cnt_reg, name_cnt_next;
    logic                   name_ovf_reg, name_ovf_next;
    logic [NUMBER_BITS-1:0] num_acc_reg, num_acc_next;
    logic                   num_ovf_reg, num_ovf_next;

    // output queue
    tok_t       fifo_mem [4];
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [2:0] fifo_cnt_reg, fifo_cnt_next;

    logic accept, advance, pop;

    logic [7:0] c;
    logic       is_alpha, is_digit;
    logic       do_normal;
    logic       slash_emit, close_emit, sym_emit;
    tok_t       slash_tok, close_tok, sym_tok;
    tok_t       res0, res1;
    logic [1:0] res_cnt;
    logic       kw_hit;
    logic [2:0] kw_idx;
    logic [EXT_BITS-1:0] acc_ext, acc_times10;

    assign pop       = tok_valid && !tok_stall;
    assign advance   = src_valid_reg && (3'(fifo_cnt_reg - {2'b00, pop}) <= 3'd2);
    assign src_stall = src_valid_reg && !advance;
    assign accept    = src_valid && !src_stall;
    assign tok_valid = (fifo_cnt_reg != 3'd0);
    assign tok_data  = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        src_valid_next = src_valid_reg;
        if (accept)
        begin
            src_valid_next = 1'b1;
        end
        else if (advance)
        begin
            src_valid_next = 1'b0;
        end
    end

    // keyword match on the open name
    always_comb
    begin
        kw_hit = !name_ovf_reg;
        kw_idx = KW_INT;
        if (name_cnt_reg == KW_INT_LEN && name_buf_reg == KW_INT_TEXT)
        begin
            kw_idx = KW_INT;
        end
        else if (name_cnt_reg == KW_IF_LEN && name_buf_reg == KW_IF_TEXT)
        begin
            kw_idx = KW_IF;
        end
        else if (name_cnt_reg == KW_THEN_LEN && name_buf_reg == KW_THEN_TEXT)
        begin
            kw_idx = KW_THEN;
        end
        else if (name_cnt_reg == KW_ELSE_LEN && name_buf_reg == KW_ELSE_TEXT)
        begin
            kw_idx = KW_ELSE;
        end
        else if (name_cnt_reg == KW_ENDIF_LEN && name_buf_reg == KW_ENDIF_TEXT)
        begin
            kw_idx = KW_ENDIF;
        end
        else
        begin
            kw_hit = 1'b0;
        end
    end

    // token for whatever is open now
    always_comb
    begin
        close_tok = '0;
        case (mode_reg)
            MODE_NAME:
            begin
                close_tok.name_chars  = name_buf_reg;
                close_tok.name_length = name_cnt_reg;
                if (kw_hit)
                begin
                    close_tok.token_kind = KIND_KEYWORD;
                    close_tok.keyword_id = kw_idx;
                end
                else
                begin
                    close_tok.token_kind     = KIND_IDENT;
                    close_tok.name_truncated = name_ovf_reg;
                end
            end
            MODE_NUMBER:
            begin
                close_tok.token_kind       = KIND_CONSTANT;
                close_tok.number_value     = 32'(64'(num_acc_reg));
                close_tok.number_saturated = num_ovf_reg;
            end
            default:
            begin
                close_tok = '0;
            end
        endcase
    end

    assign c        = src_reg.ch;
    assign is_alpha = (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
    assign is_digit = (c >= CH_ZERO && c <= CH_NINE);
    // acc * 10 + digit, carried wide so overflow shows in the top bits
    assign acc_ext     = EXT_BITS'(num_acc_reg);
    assign acc_times10 = (acc_ext << 3) + (acc_ext << 1) + EXT_BITS'(c - CH_ZERO);

    always_comb
    begin
        in_block_next   = in_block_reg;
        in_line_next    = in_line_reg;
        pend_slash_next = pend_slash_reg;
        pend_star_next  = pend_star_reg;
        mode_next       = mode_reg;
        name_buf_next   = name_buf_reg;
        name_cnt_next   = name_cnt_reg;
        name_ovf_next   = name_ovf_reg;
        num_acc_next    = num_acc_reg;
        num_ovf_next    = num_ovf_reg;
        do_normal       = 1'b0;
        slash_emit      = 1'b0;
        close_emit      = 1'b0;
        sym_emit        = 1'b0;
        slash_tok       = '0;
        slash_tok.token_kind  = KIND_OPERATOR;
        slash_tok.symbol_char = CH_SLASH;
        sym_tok         = '0;
        sym_tok.symbol_char   = c;
        sym_tok.token_kind    = KIND_OPERATOR;

        if (src_reg.end_of_line)
        begin
            in_line_next   = 1'b0;
            pend_star_next = 1'b0;
            if (pend_slash_reg)
            begin
                pend_slash_next = 1'b0;
                slash_emit      = 1'b1;
            end
            close_emit    = (mode_reg != MODE_NONE);
            mode_next     = MODE_NONE;
            name_buf_next = '0;
            name_cnt_next = '0;
            name_ovf_next = 1'b0;
            num_acc_next  = '0;
            num_ovf_next  = 1'b0;
        end
        else if (in_line_reg)
        begin
            in_line_next = 1'b1;
        end
        else if (in_block_reg)
        begin
            if (pend_star_reg && c == CH_SLASH)
            begin
                in_block_next  = 1'b0;
                pend_star_next = 1'b0;
            end
            else
            begin
                pend_star_next = (c == CH_STAR);
            end
        end
        else if (pend_slash_reg)
        begin
            pend_slash_next = 1'b0;
            if (c == CH_STAR)
            begin
                in_block_next  = 1'b1;
                pend_star_next = 1'b0;
            end
            else if (c == CH_SLASH)
            begin
                in_line_next = 1'b1;
            end
            else
            begin
                slash_emit = 1'b1;
                do_normal  = 1'b1;
            end
        end
        else
        begin
            do_normal = 1'b1;
        end

        if (do_normal)
        begin
            if (mode_reg == MODE_NAME && (is_alpha || is_digit))
            begin
                if (name_cnt_reg < KEEP_CHARS)
                begin
                    name_buf_next = name_buf_reg | (64'(c) << {name_cnt_reg[2:0], 3'b000});
                    name_cnt_next = name_cnt_reg + 4'd1;
                end
                else
                begin
                    name_ovf_next = 1'b1;
                end
            end
            else if (mode_reg == MODE_NUMBER && is_digit)
            begin
                if (num_ovf_reg || acc_times10[EXT_BITS-1:NUMBER_BITS] != '0)
                begin
                    num_acc_next = '1;
                    num_ovf_next = 1'b1;
                end
                else
                begin
                    num_acc_next = acc_times10[NUMBER_BITS-1:0];
                end
            end
            else
            begin
                close_emit    = (mode_reg != MODE_NONE);
                mode_next     = MODE_NONE;
                name_buf_next = '0;
                name_cnt_next = '0;
                name_ovf_next = 1'b0;
                num_acc_next  = '0;
                num_ovf_next  = 1'b0;
                if (c == CH_SLASH)
                begin
                    pend_slash_next = 1'b1;
                end
                else if (is_alpha)
                begin
                    mode_next     = MODE_NAME;
                    name_buf_next = 64'(c);
                    name_cnt_next = 4'd1;
                end
                else if (is_digit)
                begin
                    mode_next    = MODE_NUMBER;
                    num_acc_next = NUMBER_BITS'(c - CH_ZERO);
                end
                else if (c == CH_MINUS || c == CH_PLUS || c == CH_STAR || c == CH_GT)
                begin
                    sym_emit = 1'b1;
                end
                else if (c == CH_COMMA || c == CH_SEMI || c == CH_LPAREN ||
                         c == CH_RPAREN || c == CH_LBRACE || c == CH_RBRACE)
                begin
                    sym_emit           = 1'b1;
                    sym_tok.token_kind = KIND_SYMBOL;
                end
            end
        end
    end

    // pack up to two tokens in order: slash, closed token, new symbol
    always_comb
    begin
        res0    = slash_emit ? slash_tok : (close_emit ? close_tok : sym_tok);
        res1    = (slash_emit && close_emit) ? close_tok : sym_tok;
        res_cnt = 2'({1'b0, slash_emit} + {1'b0, close_emit} + {1'b0, sym_emit});
        res0.last = (res_cnt == 2'd1);
        res1.last = 1'b1;
    end

    always_comb
    begin
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        fifo_cnt_next = 3'(fifo_cnt_reg - {2'b00, pop});
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 2'd1;
        end
        if (advance)
        begin
            wr_ptr_next   = wr_ptr_reg + res_cnt;
            fifo_cnt_next = 3'(fifo_cnt_reg + {1'b0, res_cnt} - {2'b00, pop});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid_reg  <= 1'b0;
            in_block_reg   <= 1'b0;
            in_line_reg    <= 1'b0;
            pend_slash_reg <= 1'b0;
            pend_star_reg  <= 1'b0;
            mode_reg       <= MODE_NONE;
            name_buf_reg   <= '0;
            name_cnt_reg   <= '0;
            name_ovf_reg   <= 1'b0;
            num_acc_reg    <= '0;
            num_ovf_reg    <= 1'b0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            fifo_cnt_reg   <= '0;
        end
        else
        begin
            src_valid_reg <= src_valid_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            fifo_cnt_reg  <= fifo_cnt_next;
            if (advance)
            begin
                in_block_reg   <= in_block_next;
                in_line_reg    <= in_line_next;
                pend_slash_reg <= pend_slash_next;
                pend_star_reg  <= pend_star_next;
                mode_reg       <= mode_next;
                name_buf_reg   <= name_buf_next;
                name_cnt_reg   <= name_cnt_next;
                name_ovf_reg   <= name_ovf_next;
                num_acc_reg    <= num_acc_next;
                num_ovf_reg    <= num_ovf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg <= src_data;
        end
        if (advance && res_cnt != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (advance && res_cnt == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + 2'd1] <= res1;
        end
    end

endmodule

@@ design/tll_checker.sv @@
// port-level checks for the toy language lexer
module tll_checker
    import tll_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic src_valid,
    input logic src_stall,
    input logic tok_valid,
    input logic tok_stall,
    input tok_t tok_data
);

    // a stalled token beat holds
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> tok_valid && $stable(tok_data))
        else $error("tok beat dropped or changed under stall");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> tok_data.token_kind <= KIND_SYMBOL)
        else $error("token kind out of range");

    // keywords are never truncated and always carry a name
    a_keyword_name: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_data.token_kind == KIND_KEYWORD |->
            !tok_data.name_truncated && tok_data.name_length >= 4'd2 &&
            tok_data.name_length <= 4'd5)
        else $error("bad keyword token");

    // number fields only on constants
    a_number_only_const: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_data.token_kind != KIND_CONSTANT |->
            tok_data.number_value == 32'd0 && !tok_data.number_saturated)
        else $error("number field set on non-constant token");

    // src is only held back while tokens are waiting
    a_stall_needs_tokens: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_stall |-> tok_valid)
        else $error("src stalled with an empty token queue");

endmodule

bind toy_language_lexer tll_checker u_tll_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_data  (tok_data)
);
